@@ sv/usb_capture_record_parser_top_assert.svh @@
// Assertion macros used by the capture parser checker.
`ifndef USB_CAPTURE_RECORD_PARSER_TOP_ASSERT_SVH
`define USB_CAPTURE_RECORD_PARSER_TOP_ASSERT_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define USBCAP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define USBCAP_ASSERT_IMPLY(name, pre, post, msg) \
  `USBCAP_ASSERT(name, (pre) |-> (post), msg)

// Next-cycle implication.
`define USBCAP_ASSERT_NEXT(name, pre, post, msg) \
  `USBCAP_ASSERT(name, (pre) |=> (post), msg)

`endif

@@ sv/usbcap_pkg.sv @@
// Types, constants and helper functions of the USB capture record parser.
package usbcap_pkg;

  typedef enum logic [3:0] {
    PH_FILE    = 4'b0001,
    PH_REC_HDR = 4'b0010,
    PH_BODY    = 4'b0100,
    PH_REJECT  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_NOT_PCAP  = 3'd2,
    ST_PCAPNG    = 3'd3,
    ST_BAD_LINK  = 3'd4
  } status_e;

  localparam logic [15:0] MAGIC_BE     = 16'ha1b2;
  localparam logic [15:0] MAGIC_LE     = 16'hd4c3;
  localparam logic [15:0] MAGIC_LE_ALT = 16'h4d3c;
  localparam logic [15:0] MAGIC_NG     = 16'h0a0d;
  localparam logic [31:0] LINK_USB      = 32'd189;
  localparam logic [31:0] LINK_USB_MMAP = 32'd220;
  localparam logic [7:0]  TYPE_SUBMIT   = 8'h53;
  localparam logic [7:0]  TYPE_COMPLETE = 8'h43;
  localparam logic [19:0] USEC_PER_SEC  = 20'd1000000;

  // Byte counter saturates at the first payload offset.
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned PROD_W  = 52;
  localparam int unsigned Q_DEPTH = 3;
  localparam int unsigned Q_CNT_W = 2;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         transfer_type;
    logic [7:0]         endpoint_number;
    logic [7:0]         device_number;
    logic [31:0]        request_length;
    logic               is_completion;
    logic signed [63:0] time_micros;
    logic [7:0]         payload_byte;
    logic               record_end;
    status_e            status;
  } res_t;

  function automatic status_e file_check(logic [15:0] magic, logic [31:0] link);
    status_e st;
    if (magic == MAGIC_BE || magic == MAGIC_LE || magic == MAGIC_LE_ALT) begin
      st = (link == LINK_USB || link == LINK_USB_MMAP) ? ST_OK : ST_BAD_LINK;
    end else if (magic == MAGIC_NG) begin
      st = ST_PCAPNG;
    end else begin
      st = ST_NOT_PCAP;
    end
    return st;
  endfunction

  function automatic logic [31:0] shift32(logic [31:0] w, logic [7:0] b, logic be);
    return be ? {w[23:0], b} : {b, w[31:8]};
  endfunction

  function automatic logic [63:0] shift64(logic [63:0] w, logic [7:0] b, logic be);
    return be ? {w[55:0], b} : {b, w[63:8]};
  endfunction

endpackage

@@ sv/usbcap_if.sv @@
// Stream interfaces of the capture parser: file bytes in, results out.
interface usbcap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface usbcap_out_if;
  logic                valid;
  logic                ready;
  usbcap_pkg::kind_e   kind;
  logic [7:0]          transfer_type;
  logic [7:0]          endpoint_number;
  logic [7:0]          device_number;
  logic [31:0]         request_length;
  logic                is_completion;
  logic signed [63:0]  time_micros;
  logic [7:0]          payload_byte;
  logic                record_end;
  usbcap_pkg::status_e status;

  modport source (output valid, output kind, output transfer_type, output endpoint_number,
                  output device_number, output request_length, output is_completion,
                  output time_micros, output payload_byte, output record_end,
                  output status, input ready);
  modport sink   (input valid, input kind, input transfer_type, input endpoint_number,
                  input device_number, input request_length, input is_completion,
                  input time_micros, input payload_byte, input record_end,
                  input status, output ready);
endinterface

@@ sv/usb_capture_record_parser_top.sv @@
// A result is written into the registered result queue; out_o shows its head.
// Throughput: one file byte per cycle; the three-entry result queue drops
// in ready while two or more results wait, since the last byte may cause two.
// Timestamp: one 32x20 multiplier, used at body bytes 24 and 25.
// Reset: rst_ni clears the parser state and empties the result queue; the end
// of a file also returns the parser to its reset state.
module usb_capture_record_parser_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  usbcap_in_if.sink            in_i,
  usbcap_out_if.source         out_o
);

  usbcap_pkg::phase_e phase_q, phase_d;
  logic [usbcap_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic        be_q, be_d;
  logic [15:0] magic_q, magic_d;
  logic [31:0] word_q, word_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  kind_byte_q, kind_byte_d;
  logic [7:0]  xfer_q, xfer_d;
  logic [7:0]  ep_q, ep_d;
  logic [7:0]  dev_q, dev_d;
  logic [31:0] len_q, len_d;
  logic [63:0] secs_q, secs_d;
  logic [31:0] usec_q, usec_d;
  logic [63:0] acc_q, acc_d;
  logic        accepted_q, accepted_d;

  logic        in_fire;
  logic [7:0]  b;
  logic [31:0] mul_a;
  logic [usbcap_pkg::PROD_W-1:0] prod;
  logic [31:0] rem_next;
  logic        last;
  usbcap_pkg::res_t rec_res, stat_res, r0, r1;
  logic [usbcap_pkg::Q_CNT_W-1:0] n_res;
  logic        rec_valid;

  usbcap_pkg::res_t q_q [usbcap_pkg::Q_DEPTH];
  usbcap_pkg::res_t q_d [usbcap_pkg::Q_DEPTH];
  usbcap_pkg::res_t q_s [usbcap_pkg::Q_DEPTH];
  logic [usbcap_pkg::Q_CNT_W-1:0] qcnt_q, qcnt_d, base;
  logic pop;

  assign b       = in_i.data_byte;
  assign in_fire = in_i.valid && in_i.ready;
  assign in_i.ready = qcnt_q <= usbcap_pkg::Q_CNT_W'(usbcap_pkg::Q_DEPTH - 2);

  // Low half of seconds at byte 24, high half at byte 25.
  assign mul_a = (cnt_q == 7'd24) ? secs_q[31:0] : secs_q[63:32];
  assign prod  = {20'd0, mul_a} * {32'd0, usbcap_pkg::USEC_PER_SEC};
  assign rem_next = rem_q - 32'd1;
  assign last     = (rem_next == 32'd0) || in_i.end_of_file;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    be_d        = be_q;
    magic_d     = magic_q;
    word_d      = word_q;
    rem_d       = rem_q;
    kind_byte_d = kind_byte_q;
    xfer_d      = xfer_q;
    ep_d        = ep_q;
    dev_d       = dev_q;
    len_d       = len_q;
    secs_d      = secs_q;
    usec_d      = usec_q;
    acc_d       = acc_q;
    accepted_d  = accepted_q;
    rec_res     = '0;
    rec_valid   = 1'b0;
    stat_res    = '0;
    r0          = '0;
    r1          = '0;
    n_res       = '0;

    if (in_fire) begin
      case (phase_q)
        usbcap_pkg::PH_FILE: begin
          if (cnt_q == 7'd0) begin
            magic_d = {b, 8'h00};
          end else if (cnt_q == 7'd1) begin
            magic_d = {magic_q[15:8], b};
            be_d    = ({magic_q[15:8], b} == usbcap_pkg::MAGIC_BE);
          end else if (cnt_q inside {[7'd20:7'd23]}) begin
            word_d = usbcap_pkg::shift32(word_q, b, be_q);
          end
          cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'd23) begin
            cnt_d   = '0;
            phase_d = (usbcap_pkg::file_check(magic_d, word_d) == usbcap_pkg::ST_OK)
                      ? usbcap_pkg::PH_REC_HDR : usbcap_pkg::PH_REJECT;
          end
        end
        usbcap_pkg::PH_REC_HDR: begin
          if (cnt_q inside {[7'd8:7'd11]}) begin
            word_d = usbcap_pkg::shift32(word_q, b, be_q);
          end
          cnt_d = cnt_q + 7'd1;
          if (cnt_q == 7'd15) begin
            cnt_d      = '0;
            rem_d      = word_d;
            accepted_d = 1'b0;
            phase_d    = (word_d != 32'd0) ? usbcap_pkg::PH_BODY : usbcap_pkg::PH_REC_HDR;
          end
        end
        usbcap_pkg::PH_BODY: begin
          if (cnt_q == 7'd8) begin
            kind_byte_d = b;
          end else if (cnt_q == 7'd9) begin
            xfer_d = b;
          end else if (cnt_q == 7'd10) begin
            ep_d = b;
          end else if (cnt_q == 7'd11) begin
            dev_d = b;
          end else if (cnt_q inside {[7'd16:7'd23]}) begin
            secs_d = usbcap_pkg::shift64(secs_q, b, be_q);
          end else if (cnt_q inside {[7'd24:7'd27]}) begin
            usec_d = usbcap_pkg::shift32(usec_q, b, be_q);
          end else if (cnt_q inside {[7'd32:7'd35]}) begin
            len_d = usbcap_pkg::shift32(len_q, b, be_q);
          end

          // Build seconds * 1e6 + signed microseconds over three bytes.
          if (cnt_q == 7'd24) begin
            acc_d = 64'(prod);
          end else if (cnt_q == 7'd25) begin
            acc_d = acc_q + {prod[31:0], 32'd0};
          end else if (cnt_q == 7'd28) begin
            acc_d = acc_q + {{32{usec_q[31]}}, usec_q};
          end

          if (cnt_q == 7'd63) begin
            if (kind_byte_q == usbcap_pkg::TYPE_SUBMIT ||
                kind_byte_q == usbcap_pkg::TYPE_COMPLETE) begin
              accepted_d              = 1'b1;
              rec_valid               = 1'b1;
              rec_res.kind            = usbcap_pkg::KIND_HEADER;
              rec_res.transfer_type   = xfer_q;
              rec_res.endpoint_number = ep_q;
              rec_res.device_number   = dev_q;
              rec_res.request_length  = len_q;
              rec_res.is_completion   = (kind_byte_q == usbcap_pkg::TYPE_COMPLETE);
              rec_res.time_micros     = acc_q;
              rec_res.record_end      = last;
            end
          end else if (cnt_q == 7'd64 && accepted_q) begin
            rec_valid            = 1'b1;
            rec_res.kind         = usbcap_pkg::KIND_PAYLOAD;
            rec_res.payload_byte = b;
            rec_res.record_end   = last;
          end

          // Hold the counter once past the body header.
          cnt_d = (cnt_q == 7'd64) ? cnt_q : cnt_q + 7'd1;
          rem_d = rem_next;
          if (rem_next == 32'd0) begin
            cnt_d   = '0;
            phase_d = usbcap_pkg::PH_REC_HDR;
          end
        end
        usbcap_pkg::PH_REJECT: begin
          // Drop every byte until the end of the file.
        end
        default: begin
          phase_d = usbcap_pkg::PH_FILE;
        end
      endcase

      if (rec_valid) begin
        r0    = rec_res;
        n_res = usbcap_pkg::Q_CNT_W'(1);
      end

      if (in_i.end_of_file) begin
        stat_res.kind = usbcap_pkg::KIND_STATUS;
        if (phase_d == usbcap_pkg::PH_FILE) begin
          stat_res.status = usbcap_pkg::ST_TOO_SHORT;
        end else if (phase_d == usbcap_pkg::PH_REJECT) begin
          stat_res.status = usbcap_pkg::file_check(magic_d, word_d);
        end else begin
          stat_res.status = usbcap_pkg::ST_OK;
        end
        if (rec_valid) begin
          r1    = stat_res;
          n_res = usbcap_pkg::Q_CNT_W'(2);
        end else begin
          r0    = stat_res;
          n_res = usbcap_pkg::Q_CNT_W'(1);
        end

        // Return to the reset state for the next file.
        phase_d     = usbcap_pkg::PH_FILE;
        cnt_d       = '0;
        be_d        = 1'b0;
        magic_d     = '0;
        word_d      = '0;
        rem_d       = '0;
        kind_byte_d = '0;
        xfer_d      = '0;
        ep_d        = '0;
        dev_d       = '0;
        len_d       = '0;
        secs_d      = '0;
        usec_d      = '0;
        acc_d       = '0;
        accepted_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= usbcap_pkg::PH_FILE;
      cnt_q       <= '0;
      be_q        <= 1'b0;
      magic_q     <= '0;
      word_q      <= '0;
      rem_q       <= '0;
      kind_byte_q <= '0;
      xfer_q      <= '0;
      ep_q        <= '0;
      dev_q       <= '0;
      len_q       <= '0;
      secs_q      <= '0;
      usec_q      <= '0;
      acc_q       <= '0;
      accepted_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      be_q        <= be_d;
      magic_q     <= magic_d;
      word_q      <= word_d;
      rem_q       <= rem_d;
      kind_byte_q <= kind_byte_d;
      xfer_q      <= xfer_d;
      ep_q        <= ep_d;
      dev_q       <= dev_d;
      len_q       <= len_d;
      secs_q      <= secs_d;
      usec_q      <= usec_d;
      acc_q       <= acc_d;
      accepted_q  <= accepted_d;
    end
  end

  // Result queue: entry 0 is the head shown on out_o.
  assign pop  = (qcnt_q != '0) && out_o.ready;
  assign base = qcnt_q - usbcap_pkg::Q_CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < usbcap_pkg::Q_DEPTH - 1; i++) begin
      q_s[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_s[usbcap_pkg::Q_DEPTH-1] = q_q[usbcap_pkg::Q_DEPTH-1];
    for (int i = 0; i < usbcap_pkg::Q_DEPTH; i++) begin
      if (n_res != '0 && usbcap_pkg::Q_CNT_W'(i) == base) begin
        q_d[i] = r0;
      end else if (n_res == usbcap_pkg::Q_CNT_W'(2) &&
                   usbcap_pkg::Q_CNT_W'(i) == base + usbcap_pkg::Q_CNT_W'(1)) begin
        q_d[i] = r1;
      end else begin
        q_d[i] = q_s[i];
      end
    end
    qcnt_d = base + n_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qcnt_q <= '0;
    end else begin
      qcnt_q <= qcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign out_o.valid           = qcnt_q != '0;
  assign out_o.kind            = q_q[0].kind;
  assign out_o.transfer_type   = q_q[0].transfer_type;
  assign out_o.endpoint_number = q_q[0].endpoint_number;
  assign out_o.device_number   = q_q[0].device_number;
  assign out_o.request_length  = q_q[0].request_length;
  assign out_o.is_completion   = q_q[0].is_completion;
  assign out_o.time_micros     = q_q[0].time_micros;
  assign out_o.payload_byte    = q_q[0].payload_byte;
  assign out_o.record_end      = q_q[0].record_end;
  assign out_o.status          = q_q[0].status;

endmodule

@@ sv/usbcap_checker.sv @@
// Port-level assertions of the capture parser, bound to the top level.
`include "usb_capture_record_parser_top_assert.svh"

module usbcap_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input usbcap_pkg::kind_e   out_kind_i,
  input logic [7:0]          out_transfer_type_i,
  input logic [31:0]         out_request_length_i,
  input logic signed [63:0]  out_time_micros_i,
  input logic [7:0]          out_payload_byte_i,
  input logic                out_record_end_i,
  input usbcap_pkg::status_e out_status_i
);

  `USBCAP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_time_micros_i) && $stable(out_payload_byte_i), "stalled result changed")
  `USBCAP_ASSERT_IMPLY(a_status_clean, out_valid_i && out_kind_i == usbcap_pkg::KIND_STATUS, !out_record_end_i && out_payload_byte_i == 8'd0 && out_transfer_type_i == 8'd0 && out_time_micros_i == 64'sd0, "status result carries record fields")
  `USBCAP_ASSERT_IMPLY(a_payload_clean, out_valid_i && out_kind_i == usbcap_pkg::KIND_PAYLOAD, out_status_i == usbcap_pkg::ST_OK && out_request_length_i == 32'd0 && out_time_micros_i == 64'sd0, "payload result carries header fields")
  `USBCAP_ASSERT_IMPLY(a_header_clean, out_valid_i && out_kind_i == usbcap_pkg::KIND_HEADER, out_status_i == usbcap_pkg::ST_OK && out_payload_byte_i == 8'd0, "header result carries payload or status")

endmodule

bind usb_capture_record_parser_top usbcap_checker u_usbcap_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_kind_i           (out_o.kind),
  .out_transfer_type_i  (out_o.transfer_type),
  .out_request_length_i (out_o.request_length),
  .out_time_micros_i    (out_o.time_micros),
  .out_payload_byte_i   (out_o.payload_byte),
  .out_record_end_i     (out_o.record_end),
  .out_status_i         (out_o.status)
);

@@ bench/usb_capture_record_parser_top_tb.sv @@
// Testbench for the USB capture record parser: capture files in, checked results out.
`timescale 1ns / 100ps

module usb_capture_record_parser_top_tb;
  import usbcap_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TARGET_BYTES = 1350;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 300;

  typedef struct packed {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  class capture_scoreboard;
    phase_e         phase;
    int unsigned    count;
    logic           big_end;
    logic [15:0]    magic;
    logic [31:0]    word;
    logic [31:0]    remaining;
    logic [7:0]     type_byte;
    logic [7:0]     xfer;
    logic [7:0]     ep;
    logic [7:0]     dev;
    logic [31:0]    req_len;
    logic [63:0]    secs;
    logic [31:0]    usecs;
    logic           accepted;
    res_t           pending_results[$];
    int unsigned    failures;
    int unsigned    bytes_seen;

    function new();
      failures   = 0;
      bytes_seen = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase     = PH_FILE;
      count     = 0;
      big_end   = 1'b0;
      magic     = '0;
      word      = '0;
      remaining = '0;
      type_byte = '0;
      xfer      = '0;
      ep        = '0;
      dev       = '0;
      req_len   = '0;
      secs      = '0;
      usecs     = '0;
      accepted  = 1'b0;
    endfunction

    // Append one expected result behind those already waiting.
    function void expect_result(res_t r);
      pending_results.insert(pending_results.size(), r);
    endfunction

    function logic [31:0] fold32(logic [31:0] w, logic [7:0] b);
      return big_end ? {w[23:0], b} : {b, w[31:8]};
    endfunction

    function logic [63:0] fold64(logic [63:0] w, logic [7:0] b);
      return big_end ? {w[55:0], b} : {b, w[63:8]};
    endfunction

    function status_e header_verdict();
      if (magic == MAGIC_BE || magic == MAGIC_LE || magic == MAGIC_LE_ALT) begin
        if (word == LINK_USB || word == LINK_USB_MMAP) return ST_OK;
        return ST_BAD_LINK;
      end
      if (magic == MAGIC_NG) return ST_PCAPNG;
      return ST_NOT_PCAP;
    endfunction

    // Advance the parser by one accepted file byte and queue what it yields.
    function void parse_byte(logic [7:0] b, logic eof);
      res_t        r;
      logic        last;
      int unsigned i;
      bytes_seen++;
      case (phase)
        PH_FILE: begin
          if (count == 0) begin
            magic = {b, 8'h00};
          end else if (count == 1) begin
            magic[7:0] = b;
            big_end = (magic == MAGIC_BE);
          end else if (count >= 20 && count <= 23) begin
            word = fold32(word, b);
          end
          count++;
          if (count == 24) begin
            count = 0;
            phase = (header_verdict() == ST_OK) ? PH_REC_HDR : PH_REJECT;
          end
        end
        PH_REC_HDR: begin
          if (count >= 8 && count <= 11) word = fold32(word, b);
          count++;
          if (count == 16) begin
            count = 0;
            remaining = word;
            accepted = 1'b0;
            phase = (remaining != 0) ? PH_BODY : PH_REC_HDR;
          end
        end
        PH_BODY: begin
          i = count;
          if (i == 8) type_byte = b;
          else if (i == 9) xfer = b;
          else if (i == 10) ep = b;
          else if (i == 11) dev = b;
          else if (i >= 16 && i <= 23) secs = fold64(secs, b);
          else if (i >= 24 && i <= 27) usecs = fold32(usecs, b);
          else if (i >= 32 && i <= 35) req_len = fold32(req_len, b);
          remaining--;
          last = (remaining == 0) || eof;
          if (i == 63) begin
            if (type_byte == TYPE_SUBMIT || type_byte == TYPE_COMPLETE) begin
              accepted = 1'b1;
              r = '0;
              r.kind            = KIND_HEADER;
              r.transfer_type   = xfer;
              r.endpoint_number = ep;
              r.device_number   = dev;
              r.request_length  = req_len;
              r.is_completion   = (type_byte == TYPE_COMPLETE);
              // microseconds are signed; the sum wraps at 64 bits
              r.time_micros     = secs * 64'd1000000 + {{32{usecs[31]}}, usecs};
              r.record_end      = last;
              expect_result(r);
            end
          end else if (i > 63 && accepted) begin
            r = '0;
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.record_end   = last;
            expect_result(r);
          end
          count++;
          if (remaining == 0) begin
            count = 0;
            phase = PH_REC_HDR;
          end
        end
        default: begin
        end
      endcase
      if (eof) begin
        r = '0;
        r.kind = KIND_STATUS;
        if (phase == PH_FILE) r.status = ST_TOO_SHORT;
        else if (phase == PH_REJECT) r.status = header_verdict();
        else r.status = ST_OK;
        expect_result(r);
        clear_state();
      end
    endfunction

    function string show(res_t r);
      return $sformatf({"kind=%0d xfer=%02h ep=%02h dev=%02h len=%08h cpl=%0b ",
                        "us=%016h pay=%02h end=%0b st=%0d"},
                       r.kind, r.transfer_type, r.endpoint_number, r.device_number,
                       r.request_length, r.is_completion, r.time_micros,
                       r.payload_byte, r.record_end, r.status);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_result(res_t got);
      res_t  want;
      string diff;
      if (pending_results.size() == 0) begin
        note_failure({"result with nothing pending: ", show(got)});
        return;
      end
      want = pending_results.pop_front();
      diff = "";
      if (got.kind !== want.kind) diff = {diff, " kind"};
      if (got.transfer_type !== want.transfer_type) diff = {diff, " transfer_type"};
      if (got.endpoint_number !== want.endpoint_number) diff = {diff, " endpoint_number"};
      if (got.device_number !== want.device_number) diff = {diff, " device_number"};
      if (got.request_length !== want.request_length) diff = {diff, " request_length"};
      if (got.is_completion !== want.is_completion) diff = {diff, " is_completion"};
      if (got.time_micros !== want.time_micros) diff = {diff, " time_micros"};
      if (got.payload_byte !== want.payload_byte) diff = {diff, " payload_byte"};
      if (got.record_end !== want.record_end) diff = {diff, " record_end"};
      if (got.status !== want.status) diff = {diff, " status"};
      if (diff != "") begin
        note_failure({"field(s)", diff, "\n  expected ", show(want),
                      "\n  actual   ", show(got)});
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  usbcap_in_if  in_bus();
  usbcap_out_if out_bus();

  usb_capture_record_parser_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  capture_scoreboard sb = new();
  file_byte_t        stim_q[$];
  logic [7:0]        file_bytes[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Append one byte to the file under construction.
  function automatic void add_byte(logic [7:0] v);
    file_bytes.insert(file_bytes.size(), v);
  endfunction

  // Cut the file under construction after cut bytes and flag the last one.
  task automatic emit_file(int cut);
    for (int k = 0; k < cut; k++) stim_q.insert(stim_q.size(), {file_bytes[k], k == cut - 1});
    file_bytes.delete();
  endtask

  // Write n bytes of v at offset at of the region starting at base, within lim.
  task automatic place(int base, int lim, int at, logic [63:0] v, int n, bit be);
    for (int k = 0; k < n; k++) begin
      if (at + k < lim) file_bytes[base + at + k] = be ? v[8*(n-1-k) +: 8] : v[8*k +: 8];
    end
  endtask

  task automatic add_file_header(logic [15:0] magic, logic [31:0] link, bit be);
    int base;
    base = file_bytes.size();
    repeat (24) add_byte(8'($urandom));
    file_bytes[base]     = magic[15:8];
    file_bytes[base + 1] = magic[7:0];
    place(base, 24, 20, link, 4, be);
  endtask

  // tmode: 0 random fields, 1 all fields at their top, 2 all at their bottom.
  task automatic add_record(bit be, logic [31:0] caplen, int nbody, logic [7:0] rtype,
                            int tmode);
    int          hbase;
    int          bbase;
    logic [63:0] secs;
    logic [31:0] usecs;
    logic [31:0] rlen;
    hbase = file_bytes.size();
    bbase = hbase + 16;
    repeat (16 + nbody) add_byte(8'($urandom));
    place(hbase, 16, 8, caplen, 4, be);
    secs  = {$urandom, $urandom};
    usecs = $urandom;
    rlen  = $urandom;
    if (tmode == 1) begin
      secs  = '1;
      usecs = 32'h7fff_ffff;
      rlen  = '1;
    end else if (tmode == 2) begin
      secs  = '0;
      usecs = 32'h8000_0000;
      rlen  = '0;
    end
    place(bbase, nbody, 8, rtype, 1, be);
    place(bbase, nbody, 16, secs, 8, be);
    place(bbase, nbody, 24, usecs, 4, be);
    place(bbase, nbody, 32, rlen, 4, be);
    if (tmode != 0) place(bbase, nbody, 9, (tmode == 1) ? '1 : '0, 3, be);
  endtask

  task automatic add_random_file();
    int          sel;
    int          nrec;
    int          caplen_sel;
    int          nbody;
    int          last_start;
    int          cut;
    int          tsel;
    int          tmode;
    bit          be;
    bit          huge;
    logic [15:0] magic;
    logic [31:0] link;
    logic [31:0] caplen;
    logic [7:0]  rtype;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      repeat ($urandom_range(1, 23)) add_byte(8'($urandom));
      emit_file(file_bytes.size());
      return;
    end
    if (sel <= 6) magic = MAGIC_BE;
    else if (sel <= 12) magic = MAGIC_LE;
    else if (sel <= 16) magic = MAGIC_LE_ALT;
    else if (sel == 17) magic = MAGIC_NG;
    else if (sel == 18) magic = 16'($urandom);
    else magic = MAGIC_LE;
    be   = (magic == MAGIC_BE);
    link = (sel == 19) ? $urandom : ($urandom_range(0, 1) ? LINK_USB : LINK_USB_MMAP);
    add_file_header(magic, link, be);
    if (sel >= 17) begin
      // rejected file: the rest is noise up to end of file
      repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
      emit_file(file_bytes.size());
      return;
    end
    nrec = $urandom_range(0, 4);
    last_start = file_bytes.size();
    huge = 1'b0;
    for (int r = 0; r < nrec; r++) begin
      last_start = file_bytes.size();
      caplen_sel = $urandom_range(0, 19);
      if (caplen_sel <= 1) caplen = 0;
      else if (caplen_sel <= 4) caplen = $urandom_range(1, 63);
      else if (caplen_sel <= 6) caplen = 64;
      else caplen = $urandom_range(65, 96);
      nbody = caplen;
      if (r == nrec - 1 && $urandom_range(0, 9) == 0) begin
        // captured length far beyond the file: end of file closes the body
        huge   = 1'b1;
        caplen = $urandom | 32'h8000_0000;
        nbody  = $urandom_range(40, 100);
      end
      tsel = $urandom_range(0, 9);
      if (tsel <= 3) rtype = TYPE_SUBMIT;
      else if (tsel <= 7) rtype = TYPE_COMPLETE;
      else rtype = 8'($urandom);
      tsel  = $urandom_range(0, 9);
      tmode = (tsel == 0) ? 1 : (tsel == 1) ? 2 : 0;
      add_record(be, caplen, nbody, rtype, tmode);
    end
    cut = file_bytes.size();
    if (!huge && nrec > 0 && $urandom_range(0, 2) == 0) begin
      cut = $urandom_range(last_start + 1, file_bytes.size());
    end
    emit_file(cut);
  endtask

  task automatic build_stimulus();
    int start;
    // too short
    add_byte(8'hff);
    add_byte(8'h00);
    emit_file(2);
    // pcapng magic, then ignored bytes
    add_file_header(MAGIC_NG, LINK_USB, 1'b0);
    repeat (3) add_byte(8'($urandom));
    emit_file(file_bytes.size());
    // near-miss magic
    add_file_header(16'hd4c2, LINK_USB, 1'b0);
    emit_file(file_bytes.size());
    // good magic, wrong link type
    add_file_header(MAGIC_LE_ALT, 32'd190, 1'b0);
    emit_file(file_bytes.size());
    // big endian file through every record shape, ending inside a record header
    add_file_header(MAGIC_BE, LINK_USB, 1'b1);
    add_record(1'b1, 0, 0, TYPE_SUBMIT, 0);
    add_record(1'b1, 10, 10, TYPE_SUBMIT, 0);
    add_record(1'b1, 64, 64, TYPE_COMPLETE, 1);
    add_record(1'b1, 66, 66, TYPE_SUBMIT, 2);
    add_record(1'b1, 70, 70, 8'h58, 0);
    add_record(1'b1, 65, 65, TYPE_COMPLETE, 0);
    repeat (7) add_byte(8'($urandom));
    emit_file(file_bytes.size());
    // little endian file cut on the last header byte of a body
    add_file_header(MAGIC_LE, LINK_USB_MMAP, 1'b0);
    start = file_bytes.size();
    add_record(1'b0, 100, 100, TYPE_SUBMIT, 0);
    emit_file(start + 16 + 64);
    while (stim_q.size() < TARGET_BYTES) add_random_file();
  endtask

  task automatic send_stream();
    int burst_left;
    int gap;
    burst_left = 0;
    for (int k = 0; k < stim_q.size(); k++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        repeat (gap) begin
          @(negedge clk_i);
          in_bus.valid <= 1'b0;
        end
      end
      @(negedge clk_i);
      in_bus.valid       <= 1'b1;
      in_bus.data_byte   <= stim_q[k].data;
      in_bus.end_of_file <= stim_q[k].eof;
      @(posedge clk_i);
      while (!in_bus.ready) @(posedge clk_i);
      burst_left--;
    end
    @(negedge clk_i);
    in_bus.valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) sb.parse_byte(in_bus.data_byte, in_bus.end_of_file);
      if (out_bus.valid && out_bus.ready) begin
        got.kind            = out_bus.kind;
        got.transfer_type   = out_bus.transfer_type;
        got.endpoint_number = out_bus.endpoint_number;
        got.device_number   = out_bus.device_number;
        got.request_length  = out_bus.request_length;
        got.is_completion   = out_bus.is_completion;
        got.time_micros     = out_bus.time_micros;
        got.payload_byte    = out_bus.payload_byte;
        got.record_end      = out_bus.record_end;
        got.status          = out_bus.status;
        sb.check_result(got);
      end
    end
  end

  initial begin : result_sink
    int mode;
    int span;
    int phase_ctr;
    bit held;
    held = 1'b0;
    phase_ctr = 0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && sb.bytes_seen >= HOLD_AFTER) begin
        // hold off long enough for the result queue to fill and stall the input
        held = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk_i);
          out_bus.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk_i);
        phase_ctr++;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= ($urandom_range(0, 9) < 7);
          2: out_bus.ready <= ($urandom_range(0, 9) < 3);
          default: out_bus.ready <= (phase_ctr % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : main_flow
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.end_of_file = 1'b0;
    build_stimulus();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_stream();
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    // catch anything extra the block still emits
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) sb.note_failure("results still pending at end of run");
    if (sb.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
